// File: hdl/isd_pkg.sv
// Shared constants, codes and types of the slope detector with uphill assist.
package isd_pkg;

  localparam int ISD_DIR_FRAC  = 14;
  localparam int ISD_ONE_DIR   = 1 << ISD_DIR_FRAC;
  localparam int ISD_MAX_INIT  = 1024;
  localparam int ISD_ACC_FLOOR = 67109;

  localparam logic [1:0] FUNC_IMU  = 2'd0;
  localparam logic [1:0] FUNC_CMD  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [2:0] REG_ALPHA   = 3'd0;
  localparam logic [2:0] REG_INIT    = 3'd1;
  localparam logic [2:0] REG_COS     = 3'd2;
  localparam logic [2:0] REG_MIN_XY  = 3'd3;
  localparam logic [2:0] REG_ASSIST  = 3'd4;
  localparam logic [2:0] REG_TIMEOUT = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT,
    ST_MAG,
    ST_SQ,
    ST_SQRT,
    ST_CHK,
    ST_DLOAD,
    ST_DSTEP,
    ST_DSTORE,
    ST_POST,
    ST_DOT,
    ST_DOTFIN
  } isd_state_t;

  typedef enum logic [1:0] {
    MODE_ACC,
    MODE_SUM,
    MODE_XY
  } isd_mode_t;

endpackage

// File: hdl/imu_slope_detect_cmd_assist.sv
// Top level: slope detector with gravity reference and uphill velocity assist.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one transaction of kind in_func:
//    IMU sample (acceleration), velocity command, or publish tick.
//  - Output channel (out_valid/out_ready) carries one transaction per publish
//    tick: held command (or zeros when stale) plus uphill assist, slope flag,
//    reference status. IMU and command transactions give no output.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one
//    register per transaction; always ready. Write only while idle.
// Timing:
//  - A tick result is in the output register on the next cycle. A new
//    transaction is taken while a result waits, except a tick, which waits
//    for the output register to free up.
//  - An IMU sample runs through one shared sequencer: filter, one normalization
//    pass (square, bit-serial square root, restoring divide per component),
//    then a second pass on the direction sum once enough samples are summed,
//    or a dot product plus a pass on the xy direction once the reference is set.
//    No new transaction is taken until the IMU sample is done.
// Reset: synchronous active low rst_n clears all but the datapath and output
//  data registers to defaults; the gravity reference is rebuilt from fresh samples afterwards.
// Stall: out_ready low holds the result; nothing is dropped.
module imu_slope_detect_cmd_assist #(
  parameter int MAX_INIT_SAMPLES = isd_pkg::ISD_MAX_INIT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_acc_x,
  input  logic signed [15:0] in_acc_y,
  input  logic signed [15:0] in_acc_z,
  input  logic signed [15:0] in_lin_x,
  input  logic signed [15:0] in_lin_y,
  input  logic signed [15:0] in_lin_z,
  input  logic signed [15:0] in_ang_x,
  input  logic signed [15:0] in_ang_y,
  input  logic signed [15:0] in_ang_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_lin_x,
  output logic signed [16:0] out_lin_y,
  output logic signed [15:0] out_lin_z,
  output logic signed [15:0] out_ang_x,
  output logic signed [15:0] out_ang_y,
  output logic signed [15:0] out_ang_z,
  output logic               out_on_slope,
  output logic               out_reference_ready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import isd_pkg::*;

  localparam int SW  = $clog2(MAX_INIT_SAMPLES + 1);
  localparam int DSW = ISD_DIR_FRAC + 1 + SW;

  // configuration registers
  logic [16:0]        alpha_r;
  logic [10:0]        init_tgt_r;
  logic signed [15:0] cos_lim_r;
  logic [14:0]        min_xy_r;
  logic signed [15:0] assist_r;
  logic [15:0]        timeout_r;

  // block state
  logic signed [31:0]  filt_r [3];
  logic                primed_r;
  logic signed [DSW-1:0] dsum_r [3];
  logic [SW-1:0]       samples_r;
  logic signed [15:0]  ref_dir_r [3];
  logic                ref_set_r;
  logic                slope_r;
  logic signed [15:0]  uphill_r [2];
  logic signed [15:0]  held_r [6];
  logic                seen_r;
  logic [15:0]         age_r;

  // sequencer and shared datapath
  isd_state_t          state_r, state_nxt;
  isd_mode_t           mode_r;
  logic [1:0]          idx_r;
  logic signed [15:0]  acc_r [3];
  logic signed [31:0]  vec_r [3];
  logic [30:0]         mag_r [3];
  logic                sh_r;
  logic [63:0]         sq_acc_r;
  logic [63:0]         sx_r, sr_r, sb_r;
  logic [31:0]         rem_r;
  logic [15:0]         nlo_r, q_r;
  logic [3:0]          dcnt_r;
  logic signed [15:0]  u_r [3];
  logic signed [15:0]  g_r [3];
  logic signed [31:0]  dot_r;
  logic signed [15:0]  dotc_r;

  logic               out_valid_r;
  logic signed [16:0] o_lin_x_r, o_lin_y_r;
  logic signed [15:0] o_lin_z_r, o_ang_x_r, o_ang_y_r, o_ang_z_r;
  logic               o_slope_r, o_ref_r;

  // ---------------------------------------------------------------- shared logic
  logic [31:0] mag_c [3];
  logic        big_c;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec_r[i][31] ? 32'(-vec_r[i]) : 32'(vec_r[i]);
    end
    big_c = mag_c[0][31] | mag_c[1][31] | mag_c[2][31];
  end

  logic [16:0]         alpha_c;
  logic signed [32:0]  fdiff_c;
  logic signed [50:0]  fprod_c;
  logic signed [31:0]  fnew_c;
  logic signed [31:0]  xin_c;
  always_comb begin
    alpha_c = (alpha_r > 17'd65536) ? 17'd65536 : alpha_r;
    xin_c   = {acc_r[idx_r], 16'h0000};
    fdiff_c = 33'(xin_c) - 33'(filt_r[idx_r]);
    fprod_c = 51'(fdiff_c) * $signed({34'd0, alpha_c});
    fnew_c  = primed_r ? (filt_r[idx_r] + 32'(fprod_c >>> 16)) : xin_c;
  end

  logic [63:0] sq_term_c;
  assign sq_term_c = 64'(mag_r[idx_r]) * 64'(mag_r[idx_r]);

  logic [63:0] st_c;
  assign st_c = sr_r + sb_r;

  logic [31:0] nrm_c;
  logic [32:0] nfull_c;
  logic        low_norm_c, sum_bad_c, now_c, xy_div_c;
  logic [47:0] ns1000_c, slim_c;
  always_comb begin
    nrm_c      = sr_r[31:0];
    nfull_c    = sh_r ? {nrm_c, 1'b0} : {1'b0, nrm_c};
    low_norm_c = nfull_c < 33'(ISD_ACC_FLOOR);
    ns1000_c   = 48'(nrm_c) * 48'd1000;
    slim_c     = 48'(samples_r) << ISD_DIR_FRAC;
    sum_bad_c  = (nrm_c == 32'd0) || (ns1000_c < slim_c);
    now_c      = (dotc_r <= cos_lim_r) && (nrm_c >= 32'(min_xy_r));
    xy_div_c   = now_c && (nrm_c != 32'd0);
  end

  logic [45:0] num_c;
  logic [32:0] rem2_c;
  logic        ge_c;
  logic [15:0] qc_c;
  always_comb begin
    num_c  = {1'b0, mag_r[idx_r], 14'd0} + 46'(sr_r[31:1]);
    rem2_c = {rem_r, nlo_r[15]};
    ge_c   = rem2_c >= {1'b0, nrm_c};
    qc_c   = (q_r > 16'(ISD_ONE_DIR)) ? 16'(ISD_ONE_DIR) : q_r;
  end

  logic [31:0] tgt_c, snext_c;
  logic        more_c;
  always_comb begin
    if (init_tgt_r == 11'd0) tgt_c = 32'd1;
    else if (32'(init_tgt_r) > 32'(MAX_INIT_SAMPLES)) tgt_c = 32'(MAX_INIT_SAMPLES);
    else tgt_c = 32'(init_tgt_r);
    snext_c = 32'(samples_r) + 32'd1;
    more_c  = snext_c < tgt_c;
  end

  logic signed [31:0] dfl_c;
  assign dfl_c = dot_r >>> ISD_DIR_FRAC;

  // tick result
  logic               fresh_c;
  logic signed [19:0] c_c [2];
  logic signed [32:0] pa_c [2];
  logic signed [19:0] sum_c [2];
  logic signed [16:0] lin_c [2];
  always_comb begin
    fresh_c = seen_r && (age_r < timeout_r);
    for (int i = 0; i < 2; i++) begin
      c_c[i]  = fresh_c ? 20'(held_r[i]) : 20'sd0;
      pa_c[i] = 33'(assist_r * uphill_r[i]) + 33'sd8192;
      sum_c[i] = c_c[i] + 20'(pa_c[i] >>> ISD_DIR_FRAC);
      if (ref_set_r && slope_r) begin
        if (sum_c[i] > 20'sd65535) lin_c[i] = 17'sd65535;
        else if (sum_c[i] < -20'sd65536) lin_c[i] = -17'sd65536;
        else lin_c[i] = 17'(sum_c[i]);
      end else begin
        lin_c[i] = 17'(c_c[i]);
      end
    end
  end

  logic in_acc_c;
  assign in_acc_c = in_valid && in_ready;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc_c && in_func == FUNC_IMU) state_nxt = ST_FILT;
      ST_FILT:   if (idx_r == 2'd2) state_nxt = ST_MAG;
      ST_MAG:    state_nxt = ST_SQ;
      ST_SQ:     if (idx_r == 2'd2) state_nxt = ST_SQRT;
      ST_SQRT:   if (sb_r == 64'd1) state_nxt = ST_CHK;
      ST_CHK: begin
        case (mode_r)
          MODE_ACC: state_nxt = low_norm_c ? ST_IDLE : ST_DLOAD;
          MODE_SUM: state_nxt = sum_bad_c ? ST_IDLE : ST_DLOAD;
          default:  state_nxt = xy_div_c ? ST_DLOAD : ST_IDLE;
        endcase
      end
      ST_DLOAD:  state_nxt = ST_DSTEP;
      ST_DSTEP:  if (dcnt_r == 4'd15) state_nxt = ST_DSTORE;
      ST_DSTORE: begin
        if (idx_r == 2'd2 || (mode_r == MODE_XY && idx_r == 2'd1)) state_nxt = ST_POST;
        else state_nxt = ST_DLOAD;
      end
      ST_POST: begin
        if (mode_r == MODE_ACC) begin
          if (ref_set_r) state_nxt = ST_DOT;
          else state_nxt = more_c ? ST_IDLE : ST_MAG;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DOT:    if (idx_r == 2'd2) state_nxt = ST_DOTFIN;
      ST_DOTFIN: state_nxt = ST_MAG;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE) &&
                (!out_valid_r || out_ready || in_func != FUNC_TICK);
    cfg_ready = 1'b1;
  end

  assign out_valid           = out_valid_r;
  assign out_lin_x           = o_lin_x_r;
  assign out_lin_y           = o_lin_y_r;
  assign out_lin_z           = o_lin_z_r;
  assign out_ang_x           = o_ang_x_r;
  assign out_ang_y           = o_ang_y_r;
  assign out_ang_z           = o_ang_z_r;
  assign out_on_slope        = o_slope_r;
  assign out_reference_ready = o_ref_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r    <= 17'd6554;
      init_tgt_r <= 11'd200;
      cos_lim_r  <= 16'sd16226;
      min_xy_r   <= 15'd2458;
      assist_r   <= 16'sd205;
      timeout_r  <= 16'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALPHA:   alpha_r    <= cfg_data;
        REG_INIT:    init_tgt_r <= cfg_data[10:0];
        REG_COS:     cos_lim_r  <= $signed(cfg_data[15:0]);
        REG_MIN_XY:  min_xy_r   <= cfg_data[14:0];
        REG_ASSIST:  assist_r   <= $signed(cfg_data[15:0]);
        REG_TIMEOUT: timeout_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // output register: load on tick, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc_c && in_func == FUNC_TICK) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc_c && in_func == FUNC_TICK) begin
      o_lin_x_r <= lin_c[0];
      o_lin_y_r <= lin_c[1];
      o_lin_z_r <= fresh_c ? held_r[2] : 16'sd0;
      o_ang_x_r <= fresh_c ? held_r[3] : 16'sd0;
      o_ang_y_r <= fresh_c ? held_r[4] : 16'sd0;
      o_ang_z_r <= fresh_c ? held_r[5] : 16'sd0;
      o_slope_r <= slope_r;
      o_ref_r   <= ref_set_r;
    end
  end

  // control state of the detector and the command holder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        filt_r[i]    <= '0;
        dsum_r[i]    <= '0;
        ref_dir_r[i] <= '0;
      end
      ref_dir_r[2] <= 16'(ISD_ONE_DIR);
      primed_r     <= 1'b0;
      samples_r    <= '0;
      ref_set_r    <= 1'b0;
      slope_r      <= 1'b0;
      uphill_r[0]  <= '0;
      uphill_r[1]  <= '0;
      for (int i = 0; i < 6; i++) held_r[i] <= '0;
      seen_r       <= 1'b0;
      age_r        <= '0;
    end else begin
      if (in_acc_c && in_func == FUNC_CMD) begin
        held_r[0] <= in_lin_x;
        held_r[1] <= in_lin_y;
        held_r[2] <= in_lin_z;
        held_r[3] <= in_ang_x;
        held_r[4] <= in_ang_y;
        held_r[5] <= in_ang_z;
        seen_r    <= 1'b1;
        age_r     <= '0;
      end
      if (in_acc_c && in_func == FUNC_TICK && age_r != 16'hFFFF) begin
        age_r <= age_r + 16'd1;
      end
      case (state_r)
        ST_FILT: begin
          filt_r[idx_r] <= fnew_c;
          if (idx_r == 2'd2) primed_r <= 1'b1;
        end
        ST_CHK: begin
          if (mode_r == MODE_SUM && sum_bad_c) begin
            for (int i = 0; i < 3; i++) dsum_r[i] <= '0;
            samples_r <= '0;
          end
          if (mode_r == MODE_XY) slope_r <= now_c;
        end
        ST_POST: begin
          case (mode_r)
            MODE_ACC: begin
              if (!ref_set_r) begin
                for (int i = 0; i < 3; i++) dsum_r[i] <= dsum_r[i] + DSW'(u_r[i]);
                samples_r <= SW'(snext_c);
              end
            end
            MODE_SUM: begin
              for (int i = 0; i < 3; i++) ref_dir_r[i] <= u_r[i];
              ref_set_r <= 1'b1;
            end
            default: begin
              uphill_r[0] <= u_r[0];
              uphill_r[1] <= u_r[1];
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ACC;
      idx_r  <= '0;
      dcnt_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          mode_r <= MODE_ACC;
          idx_r  <= '0;
        end
        ST_FILT, ST_SQ, ST_DOT: idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
        ST_MAG:    idx_r <= '0;
        ST_CHK:    idx_r <= '0;
        ST_DLOAD:  dcnt_r <= '0;
        ST_DSTEP:  dcnt_r <= dcnt_r + 4'd1;
        ST_DSTORE: idx_r <= idx_r + 2'd1;
        ST_POST: begin
          idx_r <= '0;
          if (mode_r == MODE_ACC && !ref_set_r) mode_r <= MODE_SUM;
        end
        ST_DOTFIN: mode_r <= MODE_XY;
        default: ;
      endcase
    end
  end

  // shared datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        acc_r[0] <= in_acc_x;
        acc_r[1] <= in_acc_y;
        acc_r[2] <= in_acc_z;
      end
      ST_FILT: vec_r[idx_r] <= fnew_c;
      ST_MAG: begin
        // halve all magnitudes once if any reaches 2^31
        for (int i = 0; i < 3; i++) mag_r[i] <= big_c ? mag_c[i][31:1] : mag_c[i][30:0];
        sh_r     <= big_c;
        sq_acc_r <= '0;
      end
      ST_SQ: begin
        sq_acc_r <= sq_acc_r + sq_term_c;
        sx_r     <= sq_acc_r + sq_term_c;
        sr_r     <= '0;
        sb_r     <= 64'd1 << 62;
      end
      ST_SQRT: begin
        if (sx_r >= st_c) begin
          sx_r <= sx_r - st_c;
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r <= sb_r >> 2;
      end
      ST_DLOAD: begin
        rem_r <= 32'(num_c[45:16]);
        nlo_r <= num_c[15:0];
        q_r   <= '0;
      end
      ST_DSTEP: begin
        rem_r <= ge_c ? 32'(rem2_c - {1'b0, nrm_c}) : rem2_c[31:0];
        q_r   <= {q_r[14:0], ge_c};
        nlo_r <= {nlo_r[14:0], 1'b0};
      end
      ST_DSTORE: u_r[idx_r] <= vec_r[idx_r][31] ? -$signed(qc_c) : $signed(qc_c);
      ST_POST: begin
        if (mode_r == MODE_ACC) begin
          for (int i = 0; i < 3; i++) begin
            g_r[i]   <= u_r[i];
            vec_r[i] <= 32'(dsum_r[i] + DSW'(u_r[i]));
          end
          dot_r <= '0;
        end
      end
      ST_DOT: dot_r <= dot_r + 32'(ref_dir_r[idx_r] * g_r[idx_r]);
      ST_DOTFIN: begin
        if (dfl_c > 32'(ISD_ONE_DIR)) dotc_r <= 16'(ISD_ONE_DIR);
        else if (dfl_c < -32'(ISD_ONE_DIR)) dotc_r <= -16'(ISD_ONE_DIR);
        else dotc_r <= 16'(dfl_c);
        vec_r[0] <= 32'(g_r[0]);
        vec_r[1] <= 32'(g_r[1]);
        vec_r[2] <= '0;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- checks
  a_ref_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ref_set_r |=> ref_set_r) else $error("reference cleared outside reset");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE) else $error("ready while busy");

  a_samples_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(samples_r) <= 32'(MAX_INIT_SAMPLES)) else $error("sample count overflow");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POST) |-> (u_r[0] <= 16'sd16384 && u_r[0] >= -16'sd16384 &&
                              u_r[1] <= 16'sd16384 && u_r[1] >= -16'sd16384))
    else $error("unit component out of range");

  a_slope_needs_ref: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(slope_r) |-> ref_set_r) else $error("slope without reference");

endmodule

// File: tb/imu_slope_detect_cmd_assist_tb.sv
// Testbench for the IMU slope detector with uphill command assist.
`timescale 1ns / 100ps

typedef struct {
  logic signed [16:0] lin_x;
  logic signed [16:0] lin_y;
  logic signed [15:0] lin_z;
  logic signed [15:0] ang_x;
  logic signed [15:0] ang_y;
  logic signed [15:0] ang_z;
  logic               on_slope;
  logic               ref_ready;
} tick_result_t;

class isd_scoreboard;
  longint unsigned alpha, init_tgt, min_xy, timeout;
  longint          cos_lim, assist;
  longint          filt[3];
  bit              primed;
  longint          dir_sum[3];
  longint unsigned n_summed;
  longint          grav_ref[3];
  bit              ref_set, slope;
  longint          uphill[2];
  longint          held[6];
  bit              seen;
  longint unsigned age;
  tick_result_t    pending_ticks[$];
  int              errors;

  function new();
    alpha = 6554; init_tgt = 200; cos_lim = 16226; min_xy = 2458; assist = 205;
    timeout = 10;
    foreach (filt[i]) begin
      filt[i] = 0; dir_sum[i] = 0; grav_ref[i] = 0;
    end
    grav_ref[2] = isd_pkg::ISD_ONE_DIR;
    primed = 0; n_summed = 0; ref_set = 0; slope = 0;
    uphill[0] = 0; uphill[1] = 0;
    foreach (held[i]) held[i] = 0;
    seen = 0; age = 0; errors = 0;
  endfunction

  task report(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  function void set_reg(logic [2:0] idx, logic [16:0] d);
    case (idx)
      isd_pkg::REG_ALPHA:   alpha = d;
      isd_pkg::REG_INIT:    init_tgt = d[10:0];
      isd_pkg::REG_COS:     cos_lim = longint'($signed(d[15:0]));
      isd_pkg::REG_MIN_XY:  min_xy = d[14:0];
      isd_pkg::REG_ASSIST:  assist = longint'($signed(d[15:0]));
      isd_pkg::REG_TIMEOUT: timeout = d[15:0];
      default: ;
    endcase
  endfunction

  function longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function longint unsigned absval(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // round half away from zero, clamp to +-1.0
  function longint scale_comp(bit neg, longint unsigned m, longint unsigned n);
    longint unsigned q;
    q = ((m << isd_pkg::ISD_DIR_FRAC) + n / 2) / n;
    if (q > isd_pkg::ISD_ONE_DIR) q = isd_pkg::ISD_ONE_DIR;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function longint unsigned normalize(input longint v[3], output longint u[3]);
    longint unsigned m[3], s2, n;
    int sh;
    s2 = 0;
    sh = 0;
    foreach (m[i]) m[i] = absval(v[i]);
    while ((m[0] >> sh) >= (64'd1 << 31) || (m[1] >> sh) >= (64'd1 << 31) ||
           (m[2] >> sh) >= (64'd1 << 31)) sh++;
    foreach (m[i]) begin
      m[i] >>= sh;
      s2 += m[i] * m[i];
    end
    n = root64(s2);
    foreach (u[i]) u[i] = 0;
    if (n == 0) return 0;
    foreach (u[i]) u[i] = scale_comp(v[i] < 0, m[i], n);
    return n << sh;
  endfunction

  function void imu_update(longint a[3]);
    longint g[3], r[3], dot, gx, gy, x;
    longint unsigned n, ns, tgt, xy, w;
    bit now;
    w = alpha > 65536 ? 65536 : alpha;
    foreach (filt[i]) begin
      x = a[i] * 65536;
      if (!primed) filt[i] = x;
      else filt[i] += ((x - filt[i]) * longint'(w)) >>> 16;
    end
    primed = 1;
    n = normalize(filt, g);
    if (n < isd_pkg::ISD_ACC_FLOOR) return;
    if (!ref_set) begin
      foreach (dir_sum[i]) dir_sum[i] += g[i];
      n_summed++;
      tgt = init_tgt == 0 ? 1 : init_tgt;
      if (tgt > isd_pkg::ISD_MAX_INIT) tgt = isd_pkg::ISD_MAX_INIT;
      if (n_summed < tgt) return;
      ns = normalize(dir_sum, r);
      // restart the average when the summed directions cancel out
      if (ns == 0 || ns * 1000 < (n_summed << isd_pkg::ISD_DIR_FRAC)) begin
        foreach (dir_sum[i]) dir_sum[i] = 0;
        n_summed = 0;
        return;
      end
      foreach (grav_ref[i]) grav_ref[i] = r[i];
      ref_set = 1;
      return;
    end
    dot = 0;
    foreach (g[i]) dot += grav_ref[i] * g[i];
    dot = dot >>> isd_pkg::ISD_DIR_FRAC;
    if (dot > isd_pkg::ISD_ONE_DIR) dot = isd_pkg::ISD_ONE_DIR;
    if (dot < -isd_pkg::ISD_ONE_DIR) dot = -isd_pkg::ISD_ONE_DIR;
    gx = g[0];
    gy = g[1];
    xy = root64(absval(gx) * absval(gx) + absval(gy) * absval(gy));
    now = dot <= cos_lim && xy >= min_xy;
    if (now && xy != 0) begin
      uphill[0] = scale_comp(gx < 0, absval(gx), xy);
      uphill[1] = scale_comp(gy < 0, absval(gy), xy);
    end
    slope = now;
  endfunction

  function void note_input(logic [1:0] fn, longint a[3], longint cmd[6]);
    longint c[6], p;
    bit fresh;
    tick_result_t t;
    case (fn)
      isd_pkg::FUNC_IMU: imu_update(a);
      isd_pkg::FUNC_CMD: begin
        foreach (held[i]) held[i] = cmd[i];
        seen = 1;
        age = 0;
      end
      isd_pkg::FUNC_TICK: begin
        fresh = seen && age < timeout;
        if (age < 65535) age++;
        foreach (c[i]) c[i] = fresh ? held[i] : 0;
        if (ref_set && slope) begin
          for (int i = 0; i < 2; i++) begin
            p = assist * uphill[i] + (1 << (isd_pkg::ISD_DIR_FRAC - 1));
            c[i] += p >>> isd_pkg::ISD_DIR_FRAC;
            if (c[i] > 65535) c[i] = 65535;
            if (c[i] < -65536) c[i] = -65536;
          end
        end
        t.lin_x = 17'(c[0]); t.lin_y = 17'(c[1]); t.lin_z = 16'(c[2]);
        t.ang_x = 16'(c[3]); t.ang_y = 16'(c[4]); t.ang_z = 16'(c[5]);
        t.on_slope = slope;
        t.ref_ready = ref_set;
        pending_ticks.push_back(t);
      end
      default: ;
    endcase
  endfunction

  task check_result(tick_result_t got);
    tick_result_t e;
    if (pending_ticks.size() == 0) begin
      report("result with no tick waiting");
      return;
    end
    e = pending_ticks.pop_front();
    if (got.lin_x !== e.lin_x) report($sformatf("lin_x %0d exp %0d", got.lin_x, e.lin_x));
    if (got.lin_y !== e.lin_y) report($sformatf("lin_y %0d exp %0d", got.lin_y, e.lin_y));
    if (got.lin_z !== e.lin_z) report($sformatf("lin_z %0d exp %0d", got.lin_z, e.lin_z));
    if (got.ang_x !== e.ang_x) report($sformatf("ang_x %0d exp %0d", got.ang_x, e.ang_x));
    if (got.ang_y !== e.ang_y) report($sformatf("ang_y %0d exp %0d", got.ang_y, e.ang_y));
    if (got.ang_z !== e.ang_z) report($sformatf("ang_z %0d exp %0d", got.ang_z, e.ang_z));
    if (got.on_slope !== e.on_slope)
      report($sformatf("on_slope %0b exp %0b", got.on_slope, e.on_slope));
    if (got.ref_ready !== e.ref_ready)
      report($sformatf("reference_ready %0b exp %0b", got.ref_ready, e.ref_ready));
  endtask
endclass

module imu_slope_detect_cmd_assist_tb;
  import isd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  // an IMU transaction runs with no result to show for it
  localparam int DRAIN_CYCLES = 400;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         in_func = FUNC_TICK;
  logic signed [15:0] in_acc_x = 0, in_acc_y = 0, in_acc_z = 0;
  logic signed [15:0] in_lin_x = 0, in_lin_y = 0, in_lin_z = 0;
  logic signed [15:0] in_ang_x = 0, in_ang_y = 0, in_ang_z = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [16:0] out_lin_x, out_lin_y;
  logic signed [15:0] out_lin_z, out_ang_x, out_ang_y, out_ang_z;
  logic               out_on_slope, out_reference_ready;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = 0;
  logic [16:0]        cfg_data = 0;

  isd_scoreboard sb = new();
  int            cycles = 0;
  int            burst_left = 0;
  int            items_sent = 0;

  imu_slope_detect_cmd_assist u_top (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Hang guard: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Watch both channels and the register port; values are the pre-edge ones.
  always @(posedge clk) begin
    longint a[3], c[6];
    tick_result_t r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        a = '{in_acc_x, in_acc_y, in_acc_z};
        c = '{in_lin_x, in_lin_y, in_lin_z, in_ang_x, in_ang_y, in_ang_z};
        sb.note_input(in_func, a, c);
      end
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        r.lin_x = out_lin_x; r.lin_y = out_lin_y; r.lin_z = out_lin_z;
        r.ang_x = out_ang_x; r.ang_y = out_ang_y; r.ang_z = out_ang_z;
        r.on_slope = out_on_slope; r.ref_ready = out_reference_ready;
        sb.check_result(r);
      end
    end
  end

  // Receiver stall pattern: free-running, random, sparse, and long holds.
  int stall_mode = 0, stall_cnt = 0, hold_left = 0;
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt  <= $urandom_range(20, 120);
    end else stall_cnt <= stall_cnt - 1;
    case (stall_mode)
      0: out_ready <= 1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: begin
        if (hold_left > 0) begin
          hold_left <= hold_left - 1;
          out_ready <= 0;
        end else begin
          hold_left <= $urandom_range(0, 40);
          out_ready <= 1;
        end
      end
    endcase
  end

  // Drive one transaction and hold it until taken; end of burst drops valid.
  task send(logic [1:0] fn, logic [15:0] ax, ay, az,
            logic [15:0] lx, ly, lz, wx, wy, wz);
    in_valid <= 1;
    in_func  <= fn;
    in_acc_x <= ax; in_acc_y <= ay; in_acc_z <= az;
    in_lin_x <= lx; in_lin_y <= ly; in_lin_z <= lz;
    in_ang_x <= wx; in_ang_y <= wy; in_ang_z <= wz;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end else burst_left--;
  endtask

  task send_imu(int ax, int ay, int az);
    send(FUNC_IMU, ax, ay, az, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task send_cmd(logic [15:0] v);
    send(FUNC_CMD, $urandom, $urandom, $urandom, v, v, v, v, v, v);
  endtask

  task send_tick();
    send(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom);
  endtask

  task write_reg(logic [2:0] idx, logic [16:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Hold the sender until every tick result is back and IMU work has drained.
  task drain();
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] clip16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // Mostly gravity with some tilt; sometimes raw noise or near-zero.
  task send_random_imu();
    int g, k, x, y, z, sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) send_imu($urandom, $urandom, $urandom);
    else if (sel == 1) send_imu($urandom_range(0, 2) - 1, 0, $urandom_range(0, 2) - 1);
    else begin
      g = $urandom_range(6000, 20000);
      k = $urandom_range(0, 3);
      x = int'($urandom_range(0, g)) - g / 2;
      y = int'($urandom_range(0, g)) - g / 2;
      x = (k == 0) ? x / 64 : x >>> (2 - (k - 1));
      y = (k == 0) ? y / 64 : y >>> (2 - (k - 1));
      z = ($urandom_range(0, 15) == 0) ? -g : g;
      send_imu(clip16(x), clip16(y), clip16(z));
    end
  endtask

  task random_phase(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) send_random_imu();
      else if (sel < 62) begin
        send(FUNC_CMD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom);
      end else if (sel < 96) send_tick();
      else send(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom);
    end
  endtask

  task pick_config(int p);
    int unsigned alpha_pick[4] = '{0, 65536, 131071, 6554};
    int          cos_pick[4]   = '{-16384, 16384, 16226, 15000};
    int unsigned xy_pick[3]    = '{0, 16384, 2458};
    int          spd_pick[3]   = '{-32768, 32767, 205};
    int unsigned to_pick[3]    = '{0, 65535, 3};
    write_reg(REG_ALPHA, (p % 5 == 4) ? $urandom_range(0, 65536) : alpha_pick[p % 4]);
    write_reg(REG_INIT, (p % 2) ? 1024 : $urandom_range(1, 8));
    write_reg(REG_COS, (p % 5 == 4) ? $urandom_range(0, 32768) - 16384 : cos_pick[p % 4]);
    write_reg(REG_MIN_XY, (p % 4 == 3) ? $urandom_range(0, 16384) : xy_pick[p % 3]);
    write_reg(REG_ASSIST, (p % 4 == 3) ? $urandom : spd_pick[p % 3]);
    write_reg(REG_TIMEOUT, (p % 4 == 3) ? $urandom_range(1, 20) : to_pick[p % 3]);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Stale ticks, ignored code, command extremes.
    send_tick();
    send(2'd3, 0, 0, 0, 16'h7fff, 0, 0, 0, 0, 0);
    send_cmd(16'h8000);
    send_tick();
    send_cmd(16'h7fff);
    send_tick();
    // First sample primes the filter; a zero vector is below the norm floor.
    send_imu(0, 0, 0);
    send_imu(-32768, -32768, -32768);
    send_imu(32767, 32767, 32767);
    send_tick();
    drain();

    // Unfiltered samples that cancel: the gravity average must restart.
    write_reg(REG_ALPHA, 65536);
    write_reg(REG_INIT, 2);
    send_imu(0, 0, 16000);
    send_imu(0, 0, -16000);
    send_tick();
    drain();
    // Oversized target clamps; then zero acts as one and fixes the reference.
    write_reg(REG_INIT, 2047);
    send_imu(0, 0, 10240);
    send_imu(0, 0, 10240);
    drain();
    write_reg(REG_INIT, 0);
    send_imu(0, 0, 10240);
    send_tick();
    // Strong tilt with the default thresholds flags a slope.
    send_imu(5000, 2000, 9000);
    send_cmd(16'h0100);
    send_tick();
    send_imu(-7000, -7000, 6000);
    send_tick();
    drain();
    // Zero xy norm counts as a slope only with a zero minimum.
    write_reg(REG_MIN_XY, 0);
    write_reg(REG_COS, 16384);
    write_reg(REG_ASSIST, 32767);
    send_imu(0, 0, 10240);
    send_tick();
    drain();

    for (int p = 0; p < 6; p++) begin
      pick_config(p);
      random_phase(88);
      drain();
    end

    if (sb.pending_ticks.size() != 0)
      sb.report($sformatf("%0d tick results never arrived", sb.pending_ticks.size()));
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
